### src/paq_pkg.sv
// Shared types and constants for the per-address request queues.
// Used by per_address_request_queues_top; depends on nothing.
`default_nettype none

package paq_pkg;

  localparam int NODES_DEF    = 64;
  localparam int REQ_BITS_DEF = 10;
  localparam int ADDR_W       = 64;
  localparam int ID_W         = 10;
  localparam int LEN_W        = 7;

  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_POP   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_POOL_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_POP_LINK,
    S_FRONT
  } paq_state_t;

  typedef struct packed {
    logic [1:0]        operation;
    logic [ADDR_W-1:0] address;
    logic [ID_W-1:0]   request_id;
  } paq_cmd_t;

  typedef struct packed {
    status_t           status;
    logic [ID_W-1:0]   front_request;
    logic              front_valid;
    logic [LEN_W-1:0]  queue_length;
  } paq_result_t;

endpackage

`default_nettype wire

### src/per_address_request_queues_top.sv
// Per-address request queues: directory, node pool and free stack in memories.
// Depends on paq_pkg.
// Each accepted request scans up to fill directory entries, fill being the number
// of directory slots ever used (at most NODES); the directory memory is scanned one
// entry per cycle. One request at a time; busy stays high until the result is issued.
// busy drops while done is high.
// Results are a one-cycle strobe.
// Reset: synchronous, clears the controls at once; no clearing pass over memories.
`default_nettype none

module per_address_request_queues_top #(
  parameter int NODES    = paq_pkg::NODES_DEF,
  parameter int REQ_BITS = paq_pkg::REQ_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  paq_pkg::paq_cmd_t   cmd,
  output logic                busy,
  output paq_pkg::paq_result_t result,
  output logic                done
);
  import paq_pkg::*;

  localparam int IDX   = $clog2(NODES);
  localparam int CNT_W = $clog2(NODES + 1);

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] address;
    logic [IDX-1:0]    head;
    logic [IDX-1:0]    tail;
    logic [CNT_W-1:0]  count;
  } entry_t;

  // memories
  entry_t              ent_mem [NODES];
  entry_t              ent_rdata;
  entry_t              ent_wdata;
  logic [IDX-1:0]      ent_raddr;
  logic [IDX-1:0]      ent_waddr;
  logic                ent_we;

  logic [REQ_BITS-1:0] nreq_mem [NODES];
  logic [REQ_BITS-1:0] nreq_rdata;
  logic [IDX-1:0]      nreq_raddr;
  logic                nreq_we;

  logic [IDX-1:0]      link_mem [NODES];
  logic [IDX-1:0]      link_rdata;
  logic                link_we;

  logic [IDX-1:0]      fs_mem [NODES];
  logic [IDX-1:0]      fs_rdata;
  logic                fs_we;

  // control
  paq_state_t          state, state_next;
  logic [CNT_W-1:0]    rd_idx;
  logic [CNT_W-1:0]    fill;
  logic [CNT_W-1:0]    fresh;
  logic [CNT_W-1:0]    fs_cnt;
  logic                found;
  logic                have_free;

  // payload
  logic [1:0]          op_q;
  logic [ADDR_W-1:0]   addr_q;
  logic [REQ_BITS-1:0] req_q;
  logic [IDX-1:0]      cur_e;
  logic [IDX-1:0]      cur_head;
  logic [IDX-1:0]      cur_tail;
  logic [CNT_W-1:0]    cur_count;
  logic [IDX-1:0]      free_e;
  status_t             status_q;
  logic [CNT_W-1:0]    len_q;

  status_t             d_status;
  logic [CNT_W-1:0]    d_len;
  paq_result_t         result_next;
  logic                done_next;

  logic                scan_hit;
  logic                scan_last;
  logic [IDX-1:0]      scan_idx;
  logic                node_ok;
  logic [IDX-1:0]      alloc_node;
  logic [IDX-1:0]      alloc_e;

  assign busy      = (state != S_IDLE);
  assign scan_hit  = ent_rdata.valid && (ent_rdata.address == addr_q);
  assign scan_last = (rd_idx == fill);
  assign scan_idx  = IDX'(rd_idx - CNT_W'(1));
  // free stack first, then nodes never handed out
  assign node_ok    = (fs_cnt != '0) || (fresh != CNT_W'(NODES));
  assign alloc_node = (fs_cnt != '0) ? fs_rdata : fresh[IDX-1:0];
  assign alloc_e    = have_free ? free_e : fill[IDX-1:0];

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    ent_rdata <= ent_mem[ent_raddr];
  end

  always_ff @(posedge clk) begin
    if (nreq_we) begin
      nreq_mem[alloc_node] <= req_q;
    end
    nreq_rdata <= nreq_mem[nreq_raddr];
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[cur_tail] <= alloc_node;
    end
    link_rdata <= link_mem[cur_head];
  end

  // top of stack is always being read; it settles before the next request decides
  always_ff @(posedge clk) begin
    if (fs_we) begin
      fs_mem[fs_cnt[IDX-1:0]] <= cur_head;
    end
    fs_rdata <= fs_mem[IDX'(fs_cnt - CNT_W'(1))];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    ent_raddr   = rd_idx[IDX-1:0];
    ent_we      = 1'b0;
    ent_waddr   = cur_e;
    ent_wdata   = '{valid: 1'b1, address: addr_q, head: cur_head, tail: cur_tail,
                    count: cur_count};
    nreq_we     = 1'b0;
    nreq_raddr  = cur_head;
    link_we     = 1'b0;
    fs_we       = 1'b0;
    d_status    = ST_OK;
    d_len       = cur_count;
    done_next   = 1'b0;
    result_next = '{status: ST_OK, front_request: '0, front_valid: 1'b0,
                    queue_length: '0};

    case (state)
      S_IDLE: begin
        ent_raddr = '0;
        if (start) begin
          state_next = (fill == '0) ? S_DECIDE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_hit || scan_last) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        case (op_q)
          OP_PUSH: begin
            if (!node_ok) begin
              d_status = ST_POOL_FULL;
              if (found) begin
                state_next = S_FRONT;
              end else begin
                state_next         = S_IDLE;
                done_next          = 1'b1;
                result_next.status = ST_POOL_FULL;
              end
            end else if (found) begin
              nreq_we         = 1'b1;
              link_we         = 1'b1;
              ent_we          = 1'b1;
              ent_wdata.tail  = alloc_node;
              ent_wdata.count = cur_count + CNT_W'(1);
              d_len           = cur_count + CNT_W'(1);
              state_next      = S_FRONT;
            end else begin
              nreq_we     = 1'b1;
              ent_we      = 1'b1;
              ent_waddr   = alloc_e;
              ent_wdata   = '{valid: 1'b1, address: addr_q, head: alloc_node,
                              tail: alloc_node, count: CNT_W'(1)};
              state_next  = S_IDLE;
              done_next   = 1'b1;
              result_next = '{status: ST_OK, front_request: ID_W'(req_q),
                              front_valid: 1'b1, queue_length: LEN_W'(1)};
            end
          end
          OP_POP: begin
            d_len = cur_count - CNT_W'(1);
            if (!found) begin
              state_next         = S_IDLE;
              done_next          = 1'b1;
              result_next.status = ST_POP_EMPTY;
            end else begin
              fs_we = 1'b1;
              if (cur_count <= CNT_W'(1)) begin
                // last request gone: drop the directory entry
                ent_we          = 1'b1;
                ent_wdata.valid = 1'b0;
                ent_wdata.count = '0;
                state_next      = S_IDLE;
                done_next       = 1'b1;
              end else begin
                state_next = S_POP_LINK;
              end
            end
          end
          default: begin
            if (found) begin
              state_next = S_FRONT;
            end else begin
              state_next = S_IDLE;
              done_next  = 1'b1;
            end
          end
        endcase
      end
      S_POP_LINK: begin
        ent_we          = 1'b1;
        ent_wdata.head  = link_rdata;
        ent_wdata.count = cur_count - CNT_W'(1);
        nreq_raddr      = link_rdata;
        state_next      = S_FRONT;
      end
      S_FRONT: begin
        state_next  = S_IDLE;
        done_next   = 1'b1;
        result_next = '{status: status_q, front_request: ID_W'(nreq_rdata),
                        front_valid: 1'b1, queue_length: LEN_W'(len_q)};
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx    <= '0;
      fill      <= '0;
      fresh     <= '0;
      fs_cnt    <= '0;
      found     <= 1'b0;
      have_free <= 1'b0;
      done      <= 1'b0;
    end else begin
      done <= done_next;
      case (state)
        S_IDLE: begin
          if (start) begin
            rd_idx    <= CNT_W'(1);
            found     <= 1'b0;
            have_free <= 1'b0;
          end
        end
        S_SCAN: begin
          rd_idx <= rd_idx + CNT_W'(1);
          if (scan_hit) begin
            found <= 1'b1;
          end else if (!ent_rdata.valid) begin
            have_free <= 1'b1;
          end
        end
        S_DECIDE: begin
          if (op_q == OP_PUSH && node_ok) begin
            if (fs_cnt != '0) begin
              fs_cnt <= fs_cnt - CNT_W'(1);
            end else begin
              fresh <= fresh + CNT_W'(1);
            end
            if (!found && !have_free) begin
              fill <= fill + CNT_W'(1);
            end
          end
          if (op_q == OP_POP && found) begin
            fs_cnt <= fs_cnt + CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
    case (state)
      S_IDLE: begin
        if (start && !busy) begin
          op_q   <= cmd.operation;
          addr_q <= cmd.address;
          req_q  <= REQ_BITS'(cmd.request_id);
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          cur_e     <= scan_idx;
          cur_head  <= ent_rdata.head;
          cur_tail  <= ent_rdata.tail;
          cur_count <= ent_rdata.count;
        end else if (!ent_rdata.valid && !have_free) begin
          free_e <= scan_idx;
        end
      end
      S_DECIDE: begin
        status_q <= d_status;
        len_q    <= d_len;
      end
      default: ;
    endcase
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result issued without a request in flight");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_free_stack_bound: assert property (@(posedge clk) disable iff (rst)
    fs_cnt <= fresh)
    else $error("free stack holds more nodes than were handed out");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= fresh)
    else $error("directory slots used exceed nodes handed out");

  a_pop_empty_result: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_POP_EMPTY) |->
      (!result.front_valid && result.queue_length == '0))
    else $error("failed pop reports a non-empty queue");

endmodule

`default_nettype wire

### bench/per_address_request_queues_top_test.sv
// Testbench for per_address_request_queues_top: directed, pool exhaustion and random traffic.
// Results are checked against a predictor of the per-address queues kept in this file.
// Depends on paq_pkg and per_address_request_queues_top.
`timescale 1ns / 1ps

module per_address_request_queues_top_test;
  import paq_pkg::*;

  localparam int NODES = NODES_DEF;
  localparam int ITEM_TARGET = 1650;
  localparam int SETTLE_CYCLES = NODES + 20;
  localparam logic [1:0] OP_SPARE = 2'd3;  // unused code, acts as a query
  localparam logic [ID_W-1:0] ID_MAX = '1;

  logic clk;
  logic rst;
  logic start;
  paq_cmd_t cmd;
  logic busy;
  paq_result_t result;
  logic done;

  per_address_request_queues_top dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .cmd(cmd),
    .busy(busy),
    .result(result),
    .done(done)
  );

  // predicted queue state: node pool and address directory
  logic [ID_W-1:0]   pool_req  [NODES];
  int                pool_next [NODES];
  bit                pool_used [NODES];
  bit                dir_used  [NODES];
  logic [ADDR_W-1:0] dir_addr  [NODES];
  int                dir_head  [NODES];
  int                dir_tail  [NODES];
  int                dir_len   [NODES];

  paq_result_t pending_results[$];
  int errors = 0;
  int items_sent = 0;
  bit idling = 0;
  int burst_left = 1;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic paq_cmd_t make_cmd(input logic [1:0] op, input logic [ADDR_W-1:0] addr,
                                        input logic [ID_W-1:0] id);
    paq_cmd_t c;
    c.operation = op;
    c.address = addr;
    c.request_id = id;
    return c;
  endfunction

  // Applies one request to the predicted queues and returns the result it should produce.
  function automatic paq_result_t apply_request(input paq_cmd_t c);
    paq_result_t r;
    int slot;
    int node;
    slot = -1;
    node = -1;
    for (int i = 0; i < NODES; i++)
      if (slot < 0 && dir_used[i] && dir_addr[i] == c.address) slot = i;
    r = '0;
    r.status = ST_OK;
    case (c.operation)
      OP_PUSH: begin
        for (int i = 0; i < NODES; i++)
          if (node < 0 && !pool_used[i]) node = i;
        if (node < 0) begin
          r.status = ST_POOL_FULL;
        end else begin
          pool_used[node] = 1'b1;
          pool_req[node] = c.request_id;
          if (slot < 0) begin
            // a free node implies a free directory entry
            for (int i = 0; i < NODES; i++)
              if (slot < 0 && !dir_used[i]) slot = i;
            dir_used[slot] = 1'b1;
            dir_addr[slot] = c.address;
            dir_head[slot] = node;
            dir_tail[slot] = node;
            dir_len[slot] = 1;
          end else begin
            pool_next[dir_tail[slot]] = node;
            dir_tail[slot] = node;
            dir_len[slot]++;
          end
        end
      end
      OP_POP: begin
        if (slot < 0) begin
          r.status = ST_POP_EMPTY;
        end else begin
          pool_used[dir_head[slot]] = 1'b0;
          if (dir_len[slot] == 1) begin
            dir_used[slot] = 1'b0;
            slot = -1;
          end else begin
            dir_head[slot] = pool_next[dir_head[slot]];
            dir_len[slot]--;
          end
        end
      end
      default: ;
    endcase
    if (slot >= 0) begin
      r.front_request = pool_req[dir_head[slot]];
      r.front_valid = 1'b1;
      r.queue_length = LEN_W'(dir_len[slot]);
    end
    return r;
  endfunction

  function automatic bit find_live_queue(output logic [ADDR_W-1:0] addr);
    addr = '0;
    for (int i = 0; i < NODES; i++)
      if (dir_used[i]) begin
        addr = dir_addr[i];
        return 1'b1;
      end
    return 1'b0;
  endfunction

  // Holds start until the request is taken; start is left high for a back-to-back request.
  task automatic send_request(input paq_cmd_t c);
    int gap;
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
    pending_results.push_back(apply_request(c));
    items_sent++;
    if (idling) begin
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 20);
        // one gap in four is drawn from the long range
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 90) : $urandom_range(1, 4);
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic drain_all_queues();
    logic [ADDR_W-1:0] addr;
    while (find_live_queue(addr))
      send_request(make_cmd(OP_POP, addr, ID_W'($urandom_range(0, ID_MAX))));
  endtask

  task automatic report_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    paq_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, result);
        errors++;
      end else begin
        want = pending_results.pop_front();
        report_field("status", 32'(want.status), 32'(result.status));
        report_field("front_request", 32'(want.front_request), 32'(result.front_request));
        report_field("front_valid", 32'(want.front_valid), 32'(result.front_valid));
        report_field("queue_length", 32'(want.queue_length), 32'(result.queue_length));
      end
    end
  end

  task automatic test_directed();
    idling = 1'b1;
    burst_left = 3;
    send_request(make_cmd(OP_QUERY, '0, '0));
    send_request(make_cmd(OP_POP, '0, ID_MAX));            // pop of an absent queue
    send_request(make_cmd(OP_SPARE, '1, ID_MAX));          // code three is a query
    send_request(make_cmd(OP_PUSH, '0, '0));
    send_request(make_cmd(OP_PUSH, '0, ID_MAX));
    send_request(make_cmd(OP_PUSH, '1, ID_MAX));
    send_request(make_cmd(OP_PUSH, 64'h8000_0000_0000_0000, 10'h155));
    send_request(make_cmd(OP_PUSH, 64'h0000_0000_0000_0001, 10'h2aa));
    send_request(make_cmd(OP_QUERY, '0, '0));
    send_request(make_cmd(OP_SPARE, '0, '0));
    send_request(make_cmd(OP_POP, '0, '0));
    send_request(make_cmd(OP_POP, '0, '0));                // queue removed
    send_request(make_cmd(OP_POP, '0, '0));                // now absent
    send_request(make_cmd(OP_QUERY, '1, '0));
    send_request(make_cmd(OP_POP, '1, '0));
    send_request(make_cmd(OP_POP, 64'h8000_0000_0000_0000, '0));
    send_request(make_cmd(OP_QUERY, 64'h0000_0000_0000_0001, '0));
    send_request(make_cmd(OP_POP, 64'h0000_0000_0000_0001, '0));
    send_request(make_cmd(OP_PUSH, 64'h5555_5555_5555_5555, ID_MAX));
    send_request(make_cmd(OP_POP, 64'h5555_5555_5555_5555, '0));
    send_request(make_cmd(OP_PUSH, 64'haaaa_aaaa_aaaa_aaaa, '0));   // reuses freed node
    send_request(make_cmd(OP_POP, 64'haaaa_aaaa_aaaa_aaaa, '0));
    wait_drained();
  endtask

  task automatic test_pool_exhaustion();
    logic [ADDR_W-1:0] addrs [3];
    idling = 1'b1;
    for (int i = 0; i < 3; i++) addrs[i] = {$urandom(), $urandom()};
    // one queue holding every node
    repeat (NODES)
      send_request(make_cmd(OP_PUSH, addrs[0], ID_W'($urandom_range(0, ID_MAX))));
    send_request(make_cmd(OP_QUERY, addrs[0], '0));
    send_request(make_cmd(OP_PUSH, addrs[0], ID_W'($urandom_range(0, ID_MAX))));
    send_request(make_cmd(OP_PUSH, addrs[1], ID_W'($urandom_range(0, ID_MAX))));
    send_request(make_cmd(OP_POP, addrs[0], '0));
    send_request(make_cmd(OP_PUSH, addrs[1], ID_W'($urandom_range(0, ID_MAX))));
    send_request(make_cmd(OP_PUSH, addrs[2], ID_W'($urandom_range(0, ID_MAX))));
    drain_all_queues();
    // pool shared by three interleaved queues
    repeat (NODES + 4)
      send_request(make_cmd(OP_PUSH, addrs[$urandom_range(0, 2)],
                            ID_W'($urandom_range(0, ID_MAX))));
    repeat (8) send_request(make_cmd(OP_POP, addrs[$urandom_range(0, 2)], '0));
    repeat (8)
      send_request(make_cmd(OP_PUSH, addrs[$urandom_range(0, 2)],
                            ID_W'($urandom_range(0, ID_MAX))));
    drain_all_queues();
    wait_drained();
  endtask

  task automatic test_random_traffic();
    logic [ADDR_W-1:0] hot [8];
    logic [ADDR_W-1:0] addr;
    logic [1:0] op;
    int hot_n;
    int push_pct;
    int pick;
    hot[0] = '0;
    while (items_sent < ITEM_TARGET) begin
      hot_n = $urandom_range(1, 8);
      for (int i = 0; i < hot_n; i++)
        case ($urandom_range(0, 7))
          0: hot[i] = '0;
          1: hot[i] = '1;
          2: hot[i] = hot[0] ^ (64'd1 << $urandom_range(0, 63));  // near miss on one bit
          default: hot[i] = {$urandom(), $urandom()};
        endcase
      push_pct = $urandom_range(20, 90);
      idling = ($urandom_range(0, 2) != 0);
      burst_left = $urandom_range(1, 20);
      repeat ($urandom_range(40, 150)) begin
        pick = $urandom_range(0, 99);
        if (pick < push_pct) op = OP_PUSH;
        else if (pick < push_pct + (100 - push_pct) * 3 / 4) op = OP_POP;
        else op = ($urandom_range(0, 1) != 0) ? OP_QUERY : OP_SPARE;
        // stray addresses only probe, so they never leak nodes
        if (op != OP_PUSH && $urandom_range(0, 19) == 0) addr = {$urandom(), $urandom()};
        else addr = hot[$urandom_range(0, hot_n - 1)];
        send_request(make_cmd(op, addr, ID_W'($urandom_range(0, ID_MAX))));
      end
      if ($urandom_range(0, 2) != 0) drain_all_queues();
      if ($urandom_range(0, 3) == 0) wait_drained();
    end
  endtask

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    cmd <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_pool_exhaustion();
    test_random_traffic();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("per_address_request_queues_top test passed");
    end else begin
      $display("per_address_request_queues_top test failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("per_address_request_queues_top test failed");
    $finish;
  end

endmodule

### sim.f
src/paq_pkg.sv
src/per_address_request_queues_top.sv
bench/per_address_request_queues_top_test.sv
